// File: hdl/hc5t_pkg.sv
package hc5t_pkg;

    localparam int IDX_W       = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int NUM_CORNERS = 8;
    localparam int CORNER_W    = $clog2(NUM_CORNERS);
    localparam int TETS        = 5;
    localparam int TET_W       = $clog2(TETS);
    localparam int SEL_W       = 4 * CORNER_W;

    // queue depth must be a power of two, pointers wrap by overflow
    localparam int Q_DEPTH     = 16;
    localparam int SLOT_W      = $clog2(Q_DEPTH);
    localparam int CNT_W       = SLOT_W + 1;

    // restoring divider steps: full index by plane, then rest by cells_x
    localparam int DIV1_STEPS  = IDX_W;
    localparam int DIV2_STEPS  = IDX_W - CFG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = CFG_IDX_W'(1);

    localparam logic [TET_W-1:0] TET_LAST = TET_W'(TETS - 1);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        t_idx                          idx;
        logic [NUM_CORNERS-1:0][IDX_W-1:0] corner;
    } t_entry;

    typedef struct packed {
        logic  valid;
        t_slot slot;
        logic  odd;
    } t_done;

    typedef struct packed {
        logic   valid;
        logic   odd;
        t_entry data;
    } t_head;

    typedef struct packed {
        t_idx node_a;
        t_idx node_b;
        t_idx node_c;
        t_idx node_d;
        t_idx source;
        logic odd;
        logic last;
    } t_tet;

    // corner numbers of one tetrahedron, node a in the top bits
    function automatic logic [SEL_W-1:0] split_sel(input logic odd, input logic [TET_W-1:0] tet);
        logic [TET_W:0] code;
        code = {odd, tet};
        case (code)
            {1'b0, 3'd0}: split_sel = {3'd0, 3'd1, 3'd2, 3'd5};
            {1'b0, 3'd1}: split_sel = {3'd0, 3'd2, 3'd3, 3'd7};
            {1'b0, 3'd2}: split_sel = {3'd0, 3'd5, 3'd2, 3'd7};
            {1'b0, 3'd3}: split_sel = {3'd0, 3'd5, 3'd7, 3'd4};
            {1'b0, 3'd4}: split_sel = {3'd5, 3'd2, 3'd7, 3'd6};
            {1'b1, 3'd0}: split_sel = {3'd0, 3'd1, 3'd3, 3'd4};
            {1'b1, 3'd1}: split_sel = {3'd1, 3'd2, 3'd3, 3'd6};
            {1'b1, 3'd2}: split_sel = {3'd1, 3'd3, 3'd4, 3'd6};
            {1'b1, 3'd3}: split_sel = {3'd1, 3'd5, 3'd6, 3'd4};
            {1'b1, 3'd4}: split_sel = {3'd3, 3'd4, 3'd6, 3'd7};
            default:      split_sel = '0;
        endcase
    endfunction

endpackage

// File: hdl/hex_cell_to_five_tets.sv
// path: a request accepted while the back end is idle passes two input stages, 48 bit-per-stage
// divider stages, the queue mark, the load and the output register to its first tetrahedron;
// the other four follow one per cycle, and the receiver cannot stall them
// flow: a new cell is taken as the last of its five leaves the one-per-cycle result port; up to 17 cells
// in flight (16 queued, one emitting), busy is high while the 16-entry queue is full
// reset: synchronous active low, clears pipeline, queue and strobe, counts return to 1, busy high
module hex_cell_to_five_tets (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hc5t_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hc5t_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [31:0]                      i_cell_index,
    input  logic [31:0]                      i_corner_0,
    input  logic [31:0]                      i_corner_1,
    input  logic [31:0]                      i_corner_2,
    input  logic [31:0]                      i_corner_3,
    input  logic [31:0]                      i_corner_4,
    input  logic [31:0]                      i_corner_5,
    input  logic [31:0]                      i_corner_6,
    input  logic [31:0]                      i_corner_7,
    output logic                             o_valid,
    output logic [31:0]                      o_tet_node_a,
    output logic [31:0]                      o_tet_node_b,
    output logic [31:0]                      o_tet_node_c,
    output logic [31:0]                      o_tet_node_d,
    output logic [31:0]                      o_source_cell,
    output logic                             o_odd_parity,
    output logic                             o_last_tet
);

    logic             accept;
    logic             full;
    logic             pop;
    hc5t_pkg::t_slot  tail;
    hc5t_pkg::t_entry entry;
    hc5t_pkg::t_done  done;
    hc5t_pkg::t_head  head;
    hc5t_pkg::t_tet   tet;

    assign o_busy = full || !i_rst_n;
    assign accept = i_start && !o_busy;

    assign entry.idx       = i_cell_index;
    assign entry.corner[0] = i_corner_0;
    assign entry.corner[1] = i_corner_1;
    assign entry.corner[2] = i_corner_2;
    assign entry.corner[3] = i_corner_3;
    assign entry.corner[4] = i_corner_4;
    assign entry.corner[5] = i_corner_5;
    assign entry.corner[6] = i_corner_6;
    assign entry.corner[7] = i_corner_7;

    hc5t_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_idx      (i_cell_index),
        .i_slot     (tail),
        .o_done     (done)
    );

    hc5t_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (entry),
        .i_done  (done),
        .i_pop   (pop),
        .o_tail  (tail),
        .o_full  (full),
        .o_head  (head)
    );

    hc5t_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_tet   (tet)
    );

    assign o_tet_node_a  = tet.node_a;
    assign o_tet_node_b  = tet.node_b;
    assign o_tet_node_c  = tet.node_c;
    assign o_tet_node_d  = tet.node_d;
    assign o_source_cell = tet.source;
    assign o_odd_parity  = tet.odd;
    assign o_last_tet    = tet.last;

endmodule

// File: hdl/hc5t_front.sv
module hc5t_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hc5t_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hc5t_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_accept,
    input  hc5t_pkg::t_idx                   i_idx,
    input  hc5t_pkg::t_slot                  i_slot,
    output hc5t_pkg::t_done                  o_done
);

    localparam int L1 = hc5t_pkg::DIV1_STEPS - 1;
    localparam int L2 = hc5t_pkg::DIV2_STEPS - 1;

    logic [hc5t_pkg::CFG_W-1:0] r_cells_x;
    logic [hc5t_pkg::CFG_W-1:0] r_cells_y;
    logic [hc5t_pkg::CFG_W-1:0] nx;
    logic [hc5t_pkg::CFG_W-1:0] ny;
    hc5t_pkg::t_idx             r_plane;

    logic            r_a_v;
    logic            r_b_v;
    hc5t_pkg::t_slot r_a_slot;
    hc5t_pkg::t_slot r_b_slot;
    hc5t_pkg::t_idx  r_a_idx;
    hc5t_pkg::t_idx  r_b_idx;

    logic            r_d1_v    [hc5t_pkg::DIV1_STEPS];
    hc5t_pkg::t_slot r_d1_slot [hc5t_pkg::DIV1_STEPS];
    hc5t_pkg::t_idx  r_d1_rem  [hc5t_pkg::DIV1_STEPS];
    hc5t_pkg::t_idx  r_d1_dvd  [hc5t_pkg::DIV1_STEPS];
    logic            r_d1_q    [hc5t_pkg::DIV1_STEPS];

    logic                            r_d2_v    [hc5t_pkg::DIV2_STEPS];
    hc5t_pkg::t_slot                 r_d2_slot [hc5t_pkg::DIV2_STEPS];
    logic [hc5t_pkg::CFG_W-1:0]      r_d2_rem  [hc5t_pkg::DIV2_STEPS];
    logic [hc5t_pkg::DIV2_STEPS-1:0] r_d2_dvd  [hc5t_pkg::DIV2_STEPS];
    logic                            r_d2_q    [hc5t_pkg::DIV2_STEPS];
    logic                            r_d2_k0   [hc5t_pkg::DIV2_STEPS];

    // a zero count acts as one
    assign nx = (r_cells_x == '0) ? hc5t_pkg::CFG_W'(1) : r_cells_x;
    assign ny = (r_cells_y == '0) ? hc5t_pkg::CFG_W'(1) : r_cells_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= hc5t_pkg::CFG_W'(1);
            r_cells_y <= hc5t_pkg::CFG_W'(1);
            r_plane   <= hc5t_pkg::IDX_W'(1);
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == hc5t_pkg::CFG_CELLS_X)) begin
                r_cells_x <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == hc5t_pkg::CFG_CELLS_Y)) begin
                r_cells_y <= i_cfg_data;
            end
            r_plane <= {{(hc5t_pkg::IDX_W-hc5t_pkg::CFG_W){1'b0}}, nx}
                     * {{(hc5t_pkg::IDX_W-hc5t_pkg::CFG_W){1'b0}}, ny};
            r_a_v   <= i_accept;
            r_b_v   <= r_a_v;
        end
    end

    // two plain stages so the plane product has settled before the first step
    always_ff @(posedge i_clk) begin
        r_a_slot <= i_slot;
        r_a_idx  <= i_idx;
        r_b_slot <= r_a_slot;
        r_b_idx  <= r_a_idx;
    end

    for (genvar d = 0; d < hc5t_pkg::DIV1_STEPS; d++) begin : g_div1
        logic                     v_in;
        hc5t_pkg::t_slot          slot_in;
        hc5t_pkg::t_idx           rem_in;
        hc5t_pkg::t_idx           dvd_in;
        logic [hc5t_pkg::IDX_W:0] rem_sh;
        logic [hc5t_pkg::IDX_W:0] diff;
        logic                     ge;

        if (d == 0) begin : g_first
            assign v_in    = r_b_v;
            assign slot_in = r_b_slot;
            assign rem_in  = '0;
            assign dvd_in  = r_b_idx;
        end else begin : g_next
            assign v_in    = r_d1_v[d-1];
            assign slot_in = r_d1_slot[d-1];
            assign rem_in  = r_d1_rem[d-1];
            assign dvd_in  = r_d1_dvd[d-1];
        end

        assign rem_sh = {rem_in, dvd_in[hc5t_pkg::IDX_W-1]};
        assign diff   = rem_sh - {1'b0, r_plane};
        assign ge     = rem_sh >= {1'b0, r_plane};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_v[d] <= 1'b0;
            end else begin
                r_d1_v[d] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d1_slot[d] <= slot_in;
            r_d1_rem[d]  <= ge ? diff[hc5t_pkg::IDX_W-1:0] : rem_sh[hc5t_pkg::IDX_W-1:0];
            r_d1_dvd[d]  <= {dvd_in[hc5t_pkg::IDX_W-2:0], 1'b0};
            r_d1_q[d]    <= ge;
        end
    end

    // rest < nx * ny, so its upper half is already below nx
    for (genvar e = 0; e < hc5t_pkg::DIV2_STEPS; e++) begin : g_div2
        logic                            v_in;
        hc5t_pkg::t_slot                 slot_in;
        logic [hc5t_pkg::CFG_W-1:0]      rem_in;
        logic [hc5t_pkg::DIV2_STEPS-1:0] dvd_in;
        logic                            k0_in;
        logic [hc5t_pkg::CFG_W:0]        rem_sh;
        logic [hc5t_pkg::CFG_W:0]        diff;
        logic                            ge;

        if (e == 0) begin : g_first
            assign v_in    = r_d1_v[L1];
            assign slot_in = r_d1_slot[L1];
            assign rem_in  = r_d1_rem[L1][hc5t_pkg::IDX_W-1:hc5t_pkg::DIV2_STEPS];
            assign dvd_in  = r_d1_rem[L1][hc5t_pkg::DIV2_STEPS-1:0];
            assign k0_in   = r_d1_q[L1];
        end else begin : g_next
            assign v_in    = r_d2_v[e-1];
            assign slot_in = r_d2_slot[e-1];
            assign rem_in  = r_d2_rem[e-1];
            assign dvd_in  = r_d2_dvd[e-1];
            assign k0_in   = r_d2_k0[e-1];
        end

        assign rem_sh = {rem_in, dvd_in[hc5t_pkg::DIV2_STEPS-1]};
        assign diff   = rem_sh - {1'b0, nx};
        assign ge     = rem_sh >= {1'b0, nx};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_v[e] <= 1'b0;
            end else begin
                r_d2_v[e] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d2_slot[e] <= slot_in;
            r_d2_rem[e]  <= ge ? diff[hc5t_pkg::CFG_W-1:0] : rem_sh[hc5t_pkg::CFG_W-1:0];
            r_d2_dvd[e]  <= {dvd_in[hc5t_pkg::DIV2_STEPS-2:0], 1'b0};
            r_d2_q[e]    <= ge;
            r_d2_k0[e]   <= k0_in;
        end
    end

    // parity of i ^ j ^ k needs only the low bits
    assign o_done.valid = r_d2_v[L2];
    assign o_done.slot  = r_d2_slot[L2];
    assign o_done.odd   = r_d2_k0[L2] ^ r_d2_q[L2] ^ r_d2_rem[L2][0];

endmodule

// File: hdl/hc5t_queue.sv
module hc5t_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hc5t_pkg::t_entry i_entry,
    input  hc5t_pkg::t_done  i_done,
    input  logic             i_pop,
    output hc5t_pkg::t_slot  o_tail,
    output logic             o_full,
    output hc5t_pkg::t_head  o_head
);

    hc5t_pkg::t_entry             r_ring [hc5t_pkg::Q_DEPTH];
    logic                         r_odd  [hc5t_pkg::Q_DEPTH];
    logic                         r_rdy  [hc5t_pkg::Q_DEPTH];
    hc5t_pkg::t_slot              r_head;
    hc5t_pkg::t_slot              r_tail;
    logic [hc5t_pkg::CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            for (int s = 0; s < hc5t_pkg::Q_DEPTH; s++) begin
                r_rdy[s] <= 1'b0;
            end
        end else begin
            if (i_push) begin
                r_tail <= r_tail + hc5t_pkg::SLOT_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + hc5t_pkg::SLOT_W'(1);
                r_rdy[r_head] <= 1'b0;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + hc5t_pkg::CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - hc5t_pkg::CNT_W'(1);
            end
            // a slot being popped already has its parity, so these never collide
            if (i_done.valid) begin
                r_rdy[i_done.slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ring[r_tail] <= i_entry;
        end
        if (i_done.valid) begin
            r_odd[i_done.slot] <= i_done.odd;
        end
    end

    assign o_tail       = r_tail;
    assign o_full       = r_count == hc5t_pkg::CNT_W'(hc5t_pkg::Q_DEPTH);
    assign o_head.valid = r_rdy[r_head];
    assign o_head.odd   = r_odd[r_head];
    assign o_head.data  = r_ring[r_head];

endmodule

// File: hdl/hc5t_back.sv
module hc5t_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hc5t_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_valid,
    output hc5t_pkg::t_tet  o_tet
);

    logic                         r_act;
    logic [hc5t_pkg::TET_W-1:0]   r_tet;
    logic                         r_odd;
    hc5t_pkg::t_entry             r_data;
    logic                         r_out_v;
    hc5t_pkg::t_tet               r_out;
    logic                         load;
    logic [hc5t_pkg::SEL_W-1:0]   sel;

    // next cell is taken while the fifth tetrahedron of the current one goes out
    assign load  = i_head.valid && (!r_act || (r_tet == hc5t_pkg::TET_LAST));
    assign o_pop = load;
    assign sel   = hc5t_pkg::split_sel(r_odd, r_tet);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_tet   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_act;
            if (load) begin
                r_act <= 1'b1;
                r_tet <= '0;
            end else if (r_act) begin
                if (r_tet == hc5t_pkg::TET_LAST) begin
                    r_act <= 1'b0;
                end else begin
                    r_tet <= r_tet + hc5t_pkg::TET_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_head.data;
            r_odd  <= i_head.odd;
        end
        r_out.node_a <= r_data.corner[sel[4*hc5t_pkg::CORNER_W-1 -: hc5t_pkg::CORNER_W]];
        r_out.node_b <= r_data.corner[sel[3*hc5t_pkg::CORNER_W-1 -: hc5t_pkg::CORNER_W]];
        r_out.node_c <= r_data.corner[sel[2*hc5t_pkg::CORNER_W-1 -: hc5t_pkg::CORNER_W]];
        r_out.node_d <= r_data.corner[sel[hc5t_pkg::CORNER_W-1:0]];
        r_out.source <= r_data.idx;
        r_out.odd    <= r_odd;
        r_out.last   <= r_tet == hc5t_pkg::TET_LAST;
    end

    assign o_valid = r_out_v;
    assign o_tet   = r_out;

endmodule

// File: bench/hex_cell_to_five_tets_tb.sv
module hex_cell_to_five_tets_tb;

    localparam int TETS_PER_CELL = 5;
    localparam int IDLE_LIMIT    = 1000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RAND_PHASES   = 8;
    localparam int CELLS_PER_PHASE = 38;
    localparam int MAX_REPORTS   = 10;
    localparam int EXP_DEPTH     = 256;

    // register indexes past the end of the list, writes there must be dropped
    localparam logic [hc5t_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = hc5t_pkg::CFG_IDX_W'(2);
    localparam logic [hc5t_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = hc5t_pkg::CFG_IDX_W'(3);

    // lattice settings used by the directed rows
    localparam logic [2:0] SET_RESET  = 3'd0;
    localparam logic [2:0] SET_ZERO   = 3'd1;
    localparam logic [2:0] SET_MAX    = 3'd2;
    localparam logic [2:0] SET_WIDE_X = 3'd3;
    localparam logic [2:0] SET_SMALL  = 3'd4;

    // corner numbers per tetrahedron, even split first
    localparam logic [2:0] TET_CORNER [2][TETS_PER_CELL][4] = '{
        '{'{0, 1, 2, 5}, '{0, 2, 3, 7}, '{0, 5, 2, 7}, '{0, 5, 7, 4}, '{5, 2, 7, 6}},
        '{'{0, 1, 3, 4}, '{1, 2, 3, 6}, '{1, 3, 4, 6}, '{1, 5, 6, 4}, '{3, 4, 6, 7}}
    };

    typedef struct packed {
        logic [2:0]  setting;
        logic [31:0] idx;
        logic [31:0] base;   // corner n gets base + n * step
        logic [31:0] step;
        logic        typed;  // parity typed in below instead of computed
        logic        odd;
    } t_cell_row;

    localparam int NUM_ROWS = 22;
    localparam t_cell_row CELL_ROWS [NUM_ROWS] = '{
        '{SET_RESET,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
        '{SET_RESET,  32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1},
        '{SET_RESET,  32'hFFFF_FFFF, 32'h0000_0000, 32'h1111_1111, 1'b1, 1'b1},
        '{SET_RESET,  32'h8000_0000, 32'h0123_4567, 32'h1000_0001, 1'b1, 1'b0},
        '{SET_RESET,  32'h5555_5555, 32'hFFFF_FFF8, 32'h0000_0001, 1'b0, 1'b0},
        '{SET_ZERO,   32'h0000_0002, 32'hAAAA_AAAA, 32'h0101_0101, 1'b1, 1'b0},
        '{SET_ZERO,   32'h0000_0007, 32'h5555_5555, 32'h2000_0003, 1'b1, 1'b1},
        '{SET_ZERO,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0800_0000, 1'b1, 1'b1},
        '{SET_MAX,    32'h0000_0000, 32'h0000_0010, 32'h0000_0010, 1'b1, 1'b0},
        '{SET_MAX,    32'h0000_0001, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b1, 1'b1},
        '{SET_MAX,    32'h0000_FFFF, 32'h1234_5678, 32'h1111_1111, 1'b1, 1'b1},
        '{SET_MAX,    32'hFFFE_0001, 32'hFFFF_FF00, 32'h0000_0020, 1'b1, 1'b1},
        '{SET_MAX,    32'hFFFF_FFFF, 32'h0000_0100, 32'h0100_0000, 1'b0, 1'b0},
        '{SET_MAX,    32'hFFFE_0000, 32'h7FFF_FFFF, 32'h3333_3333, 1'b0, 1'b0},
        '{SET_WIDE_X, 32'h0000_FFFE, 32'h0000_0001, 32'h0000_0002, 1'b1, 1'b0},
        '{SET_WIDE_X, 32'h0000_FFFF, 32'hCAFE_0000, 32'h0000_1000, 1'b1, 1'b1},
        '{SET_WIDE_X, 32'hDEAD_BEEF, 32'h9999_9999, 32'h0F00_00F0, 1'b0, 1'b0},
        '{SET_SMALL,  32'h0000_0004, 32'h0000_0040, 32'h0000_0040, 1'b0, 1'b0},
        '{SET_SMALL,  32'h0000_0005, 32'h4000_0000, 32'h0000_0007, 1'b0, 1'b0},
        '{SET_SMALL,  32'h0000_000B, 32'hEEEE_EEEE, 32'h1000_0000, 1'b0, 1'b0},
        '{SET_SMALL,  32'h0000_000D, 32'h0F0F_0F0F, 32'h2222_2222, 1'b0, 1'b0},
        '{SET_SMALL,  32'hAAAA_AAAA, 32'h3C3C_3C3C, 32'h0000_0101, 1'b0, 1'b0}
    };

    typedef struct packed {
        logic [31:0] node_a;
        logic [31:0] node_b;
        logic [31:0] node_c;
        logic [31:0] node_d;
        logic [31:0] source;
        logic        odd;
        logic        last;
    } t_tet_rec;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [hc5t_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [hc5t_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_start;
    logic                           o_busy;
    logic [31:0]                    i_cell_index;
    logic [31:0]                    i_corner_0;
    logic [31:0]                    i_corner_1;
    logic [31:0]                    i_corner_2;
    logic [31:0]                    i_corner_3;
    logic [31:0]                    i_corner_4;
    logic [31:0]                    i_corner_5;
    logic [31:0]                    i_corner_6;
    logic [31:0]                    i_corner_7;
    logic                           o_valid;
    logic [31:0]                    o_tet_node_a;
    logic [31:0]                    o_tet_node_b;
    logic [31:0]                    o_tet_node_c;
    logic [31:0]                    o_tet_node_d;
    logic [31:0]                    o_source_cell;
    logic                           o_odd_parity;
    logic                           o_last_tet;

    logic [hc5t_pkg::CFG_W-1:0] model_cells_x;
    logic [hc5t_pkg::CFG_W-1:0] model_cells_y;
    // expected tets in order, written by the stimulus side and read by the monitor
    t_tet_rec                   exp_ring [EXP_DEPTH];
    int                         exp_wr = 0;
    int                         exp_rd = 0;
    int                         err_count = 0;
    int                         idle_cycles = 0;

    hex_cell_to_five_tets DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cell_index  (i_cell_index),
        .i_corner_0    (i_corner_0),
        .i_corner_1    (i_corner_1),
        .i_corner_2    (i_corner_2),
        .i_corner_3    (i_corner_3),
        .i_corner_4    (i_corner_4),
        .i_corner_5    (i_corner_5),
        .i_corner_6    (i_corner_6),
        .i_corner_7    (i_corner_7),
        .o_valid       (o_valid),
        .o_tet_node_a  (o_tet_node_a),
        .o_tet_node_b  (o_tet_node_b),
        .o_tet_node_c  (o_tet_node_c),
        .o_tet_node_d  (o_tet_node_d),
        .o_source_cell (o_source_cell),
        .o_odd_parity  (o_odd_parity),
        .o_last_tet    (o_last_tet)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // checkerboard parity of a cell under the current lattice counts
    function automatic logic cell_parity(input logic [31:0] idx);
        logic [63:0] nx;
        logic [63:0] ny;
        logic [63:0] plane;
        logic [63:0] k;
        logic [63:0] rest;
        logic [63:0] j;
        logic [63:0] i;
        nx = (model_cells_x == '0) ? 64'd1 : 64'(model_cells_x);
        ny = (model_cells_y == '0) ? 64'd1 : 64'(model_cells_y);
        plane = nx * ny;
        k = 64'(idx) / plane;
        rest = 64'(idx) % plane;
        j = rest / nx;
        i = rest % nx;
        return i[0] ^ j[0] ^ k[0];
    endfunction

    task automatic queue_cell_tets(input logic [31:0] idx, input logic [7:0][31:0] c,
                                   input logic odd);
        t_tet_rec rec;
        for (int t = 0; t < TETS_PER_CELL; t++) begin
            rec.node_a = c[TET_CORNER[odd][t][0]];
            rec.node_b = c[TET_CORNER[odd][t][1]];
            rec.node_c = c[TET_CORNER[odd][t][2]];
            rec.node_d = c[TET_CORNER[odd][t][3]];
            rec.source = idx;
            rec.odd    = odd;
            rec.last   = (t == TETS_PER_CELL - 1);
            exp_ring[exp_wr % EXP_DEPTH] = rec;
            exp_wr++;
        end
    endtask

    // called and returns at a falling edge, the caller drops the write enable afterwards
    task automatic write_reg(input logic [hc5t_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hc5t_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        case (idx)
            hc5t_pkg::CFG_CELLS_X: model_cells_x = data;
            hc5t_pkg::CFG_CELLS_Y: model_cells_y = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained;
        while (exp_wr != exp_rd) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_cell(input logic [31:0] idx, input logic [7:0][31:0] c, input int gap,
                             input logic typed, input logic typed_odd);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start      <= 1'b1;
        i_cell_index <= idx;
        i_corner_0   <= c[0];
        i_corner_1   <= c[1];
        i_corner_2   <= c[2];
        i_corner_3   <= c[3];
        i_corner_4   <= c[4];
        i_corner_5   <= c[5];
        i_corner_6   <= c[6];
        i_corner_7   <= c[7];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        queue_cell_tets(idx, c, typed ? typed_odd : cell_parity(idx));
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [2:0] setting);
        case (setting)
            SET_ZERO: begin
                write_reg(hc5t_pkg::CFG_CELLS_X, 16'h0000);
                write_reg(hc5t_pkg::CFG_CELLS_Y, 16'h0000);
            end
            SET_MAX: begin
                write_reg(hc5t_pkg::CFG_CELLS_X, 16'hFFFF);
                write_reg(hc5t_pkg::CFG_CELLS_Y, 16'hFFFF);
            end
            SET_WIDE_X: begin
                write_reg(hc5t_pkg::CFG_CELLS_X, 16'hFFFF);
                write_reg(hc5t_pkg::CFG_CELLS_Y, 16'h0001);
            end
            SET_SMALL: begin
                write_reg(hc5t_pkg::CFG_CELLS_X, 16'h0003);
                write_reg(hc5t_pkg::CFG_CELLS_Y, 16'h0002);
                // must not disturb the counts
                write_reg(CFG_SPARE_A, 16'h0000);
                write_reg(CFG_SPARE_B, 16'hFFFF);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_tet_rec got;
        t_tet_rec want;
        if (i_rst_n && o_valid) begin
            got = '{o_tet_node_a, o_tet_node_b, o_tet_node_c, o_tet_node_d,
                    o_source_cell, o_odd_parity, o_last_tet};
            if (exp_wr == exp_rd) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected tet: nodes %h %h %h %h cell %h odd %b last %b",
                             got.node_a, got.node_b, got.node_c, got.node_d,
                             got.source, got.odd, got.last);
            end else begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got !== want) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("tet mismatch, expected: nodes %h %h %h %h cell %h odd %b last %b",
                                 want.node_a, want.node_b, want.node_c, want.node_d,
                                 want.source, want.odd, want.last);
                        $display("tet mismatch, actual:   nodes %h %h %h %h cell %h odd %b last %b",
                                 got.node_a, got.node_b, got.node_c, got.node_d,
                                 got.source, got.odd, got.last);
                    end
                end
            end
        end
    end

    // counts cycles in which neither a request nor a tet is accepted
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("hex_cell_to_five_tets regression: fail");
            $finish;
        end
    end

    initial begin
        logic [7:0][31:0]           c;
        logic [hc5t_pkg::CFG_W-1:0] cx;
        logic [hc5t_pkg::CFG_W-1:0] cy;
        logic [63:0]                span;
        logic [31:0]                idx;
        logic                       burst;
        t_cell_row                  row;

        model_cells_x = 16'd1;
        model_cells_y = 16'd1;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_start       = 1'b0;
        i_cell_index  = '0;
        i_corner_0    = '0;
        i_corner_1    = '0;
        i_corner_2    = '0;
        i_corner_3    = '0;
        i_corner_4    = '0;
        i_corner_5    = '0;
        i_corner_6    = '0;
        i_corner_7    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = CELL_ROWS[r];
            if (r > 0 && row.setting != CELL_ROWS[r-1].setting) begin
                i_start <= 1'b0;
                wait_drained();
                apply_setting(row.setting);
                i_cfg_we <= 1'b0;
            end
            for (int n = 0; n < 8; n++)
                c[n] = row.base + 32'(n) * row.step;
            send_cell(row.idx, c, $urandom_range(0, 9), row.typed, row.odd);
        end
        i_start <= 1'b0;

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin cx = 16'($urandom_range(1, 4)); cy = 16'($urandom_range(1, 4)); end
                1: begin cx = 16'h0000; cy = 16'($urandom_range(0, 7)); end
                2: begin cx = 16'($urandom_range(2, 9)); cy = 16'h0000; end
                3: begin cx = 16'($urandom); cy = 16'($urandom); end
                4: begin cx = 16'hFFFF; cy = 16'hFFFF; end
                5: begin
                    cx = 16'hFFFF - 16'($urandom_range(0, 15));
                    cy = 16'($urandom_range(1, 3));
                end
                6: begin cx = 16'($urandom_range(1, 3)); cy = 16'hFFFF; end
                default: begin
                    cx = 16'($urandom_range(1, 16));
                    cy = 16'($urandom_range(1, 16));
                end
            endcase
            wait_drained();
            write_reg(hc5t_pkg::CFG_CELLS_X, cx);
            write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
            write_reg(hc5t_pkg::CFG_CELLS_Y, cy);
            i_cfg_we <= 1'b0;
            span = 64'((cx == '0) ? 16'd1 : cx) * 64'((cy == '0) ? 16'd1 : cy) * 64'd6;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            // every third phase runs back to back so the queue fills and busy rises
            burst = (ph % 3 == 2);
            for (int n = 0; n < CELLS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) < 6)
                    idx = $urandom_range(0, 32'(span));
                else
                    idx = $urandom;
                for (int m = 0; m < 8; m++)
                    c[m] = $urandom;
                send_cell(idx, c, burst ? 0 : $urandom_range(0, 9), 1'b0, 1'b0);
            end
            i_start <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (exp_wr != exp_rd)
            $display("%0d tets never arrived", exp_wr - exp_rd);
        if (err_count == 0 && exp_wr == exp_rd)
            $display("hex_cell_to_five_tets regression: pass");
        else
            $display("hex_cell_to_five_tets regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
hdl/hc5t_pkg.sv
hdl/hc5t_front.sv
hdl/hc5t_queue.sv
hdl/hc5t_back.sv
hdl/hex_cell_to_five_tets.sv
bench/hex_cell_to_five_tets_tb.sv
